### rtl/seg_isect_pkg.sv
// shared types and constants for the segment intersection block
// no dependencies
package seg_isect_pkg;

  localparam int CoordWidthDef = 16;
  localparam int FracBitsDef   = 16;
  localparam int OutWidth      = 32;

  typedef enum logic [1:0] {
    OUT_NONE    = 2'd0,
    OUT_POINT   = 2'd1,
    OUT_OVERLAP = 2'd2
  } outcome_e;

  // per-request control that rides along the pipeline
  typedef struct packed {
    logic     valid;
    logic     is_div;
    logic     neg_x;
    logic     neg_y;
    outcome_e outcome;
  } seg_ctl_t;

  typedef struct packed {
    outcome_e               outcome;
    logic [OutWidth-1:0]    first_x;
    logic [OutWidth-1:0]    first_y;
    logic [OutWidth-1:0]    second_x;
    logic [OutWidth-1:0]    second_y;
  } seg_res_t;

endpackage

### rtl/segment_intersection.sv
// segment intersection top: front end, a row of divider cells with one
// quotient bit per cell, and an output register with skid stage
// throughput is one request per cycle while in_stall_o is low
// reset clears all valid flags; no clearing pass, ready right after reset
module segment_intersection #(
  parameter int COORD_WIDTH = seg_isect_pkg::CoordWidthDef,
  parameter int FRAC_BITS   = seg_isect_pkg::FracBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [COORD_WIDTH-1:0]   a_start_x_i,
  input  logic signed [COORD_WIDTH-1:0]   a_start_y_i,
  input  logic signed [COORD_WIDTH-1:0]   a_end_x_i,
  input  logic signed [COORD_WIDTH-1:0]   a_end_y_i,
  input  logic signed [COORD_WIDTH-1:0]   b_start_x_i,
  input  logic signed [COORD_WIDTH-1:0]   b_start_y_i,
  input  logic signed [COORD_WIDTH-1:0]   b_end_x_i,
  input  logic signed [COORD_WIDTH-1:0]   b_end_y_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      outcome_o,
  output logic signed [seg_isect_pkg::OutWidth-1:0] first_x_o,
  output logic signed [seg_isect_pkg::OutWidth-1:0] first_y_o,
  output logic signed [seg_isect_pkg::OutWidth-1:0] second_x_o,
  output logic signed [seg_isect_pkg::OutWidth-1:0] second_y_o
);
  import seg_isect_pkg::*;

  localparam int C    = COORD_WIDTH;
  localparam int DENW = 2 * C + 2;
  localparam int Q    = C + FRAC_BITS;
  localparam int PW   = 4 * C;

  logic en;

  seg_ctl_t          ctl_c  [Q+1];
  logic [DENW-1:0]   den_c  [Q+1];
  logic [DENW-1:0]   remx_c [Q+1];
  logic [DENW-1:0]   remy_c [Q+1];
  logic [Q-1:0]      bitsx_c[Q+1];
  logic [Q-1:0]      bitsy_c[Q+1];
  logic [PW-1:0]     pnt_c  [Q+1];

  seg_isect_front #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (in_valid_i),
    .a_start_x_i (a_start_x_i),
    .a_start_y_i (a_start_y_i),
    .a_end_x_i   (a_end_x_i),
    .a_end_y_i   (a_end_y_i),
    .b_start_x_i (b_start_x_i),
    .b_start_y_i (b_start_y_i),
    .b_end_x_i   (b_end_x_i),
    .b_end_y_i   (b_end_y_i),
    .ctl_o       (ctl_c[0]),
    .den_o       (den_c[0]),
    .rem_x_o     (remx_c[0]),
    .bits_x_o    (bitsx_c[0]),
    .rem_y_o     (remy_c[0]),
    .bits_y_o    (bitsy_c[0]),
    .pnt_o       (pnt_c[0])
  );

  for (genvar i = 0; i < Q; i++) begin : g_cell
    seg_isect_cell #(
      .DENW (DENW),
      .QW   (Q),
      .PW   (PW)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .ctl_i    (ctl_c[i]),
      .den_i    (den_c[i]),
      .rem_x_i  (remx_c[i]),
      .bits_x_i (bitsx_c[i]),
      .rem_y_i  (remy_c[i]),
      .bits_y_i (bitsy_c[i]),
      .pnt_i    (pnt_c[i]),
      .ctl_o    (ctl_c[i+1]),
      .den_o    (den_c[i+1]),
      .rem_x_o  (remx_c[i+1]),
      .bits_x_o (bitsx_c[i+1]),
      .rem_y_o  (remy_c[i+1]),
      .bits_y_o (bitsy_c[i+1]),
      .pnt_o    (pnt_c[i+1])
    );
  end

  // result assembly from the last cell
  seg_ctl_t                 lctl;
  logic signed [Q:0]        qsx, qsy;
  logic signed [C-1:0]      px, py, qx, qy;
  logic signed [C+FRAC_BITS-1:0] fpx, fpy, fqx, fqy;
  seg_res_t                 res_d;
  always_comb begin
    lctl = ctl_c[Q];
    qsx  = lctl.neg_x ? -$signed({1'b0, bitsx_c[Q]}) : $signed({1'b0, bitsx_c[Q]});
    qsy  = lctl.neg_y ? -$signed({1'b0, bitsy_c[Q]}) : $signed({1'b0, bitsy_c[Q]});
    px   = $signed(pnt_c[Q][4*C-1:3*C]);
    py   = $signed(pnt_c[Q][3*C-1:2*C]);
    qx   = $signed(pnt_c[Q][2*C-1:C]);
    qy   = $signed(pnt_c[Q][C-1:0]);
    fpx  = (C+FRAC_BITS)'(px);
    fpx  = fpx <<< FRAC_BITS;
    fpy  = (C+FRAC_BITS)'(py);
    fpy  = fpy <<< FRAC_BITS;
    fqx  = (C+FRAC_BITS)'(qx);
    fqx  = fqx <<< FRAC_BITS;
    fqy  = (C+FRAC_BITS)'(qy);
    fqy  = fqy <<< FRAC_BITS;
    res_d.outcome = lctl.outcome;
    if (lctl.is_div) begin
      res_d.first_x  = OutWidth'(qsx);
      res_d.first_y  = OutWidth'(qsy);
      res_d.second_x = OutWidth'(qsx);
      res_d.second_y = OutWidth'(qsy);
    end else begin
      res_d.first_x  = OutWidth'(fpx);
      res_d.first_y  = OutWidth'(fpy);
      res_d.second_x = OutWidth'(fqx);
      res_d.second_y = OutWidth'(fqy);
    end
  end

  // output register plus skid stage
  logic     o_valid_q, s_full_q;
  seg_res_t o_q, s_q;
  logic     take, p_valid, load_o;

  assign take       = o_valid_q && !out_stall_i;
  assign en         = !s_full_q;
  assign p_valid    = lctl.valid;
  assign load_o     = !o_valid_q || take;
  assign in_stall_o = s_full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
      s_full_q  <= 1'b0;
    end else if (en) begin
      if (p_valid) begin
        if (load_o) begin
          o_valid_q <= 1'b1;
        end else begin
          s_full_q <= 1'b1;
        end
      end else if (take) begin
        o_valid_q <= 1'b0;
      end
    end else if (take) begin
      s_full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && p_valid && load_o) begin
      o_q <= res_d;
    end else if (!en && take) begin
      o_q <= s_q;
    end
    if (en && p_valid && !load_o) begin
      s_q <= res_d;
    end
  end

  assign out_valid_o = o_valid_q;
  assign outcome_o   = o_q.outcome;
  assign first_x_o   = o_q.first_x;
  assign first_y_o   = o_q.first_y;
  assign second_x_o  = o_q.second_x;
  assign second_y_o  = o_q.second_y;

  // a parked request always has a request ahead of it on the output
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_full_q |-> o_valid_q)
    else $error("skid holds a request while output is empty");

  // a stalled output with a full skid must keep the output valid next cycle
  a_skid_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_full_q && out_stall_i) |=> (s_full_q && o_valid_q))
    else $error("skid request lost while stalled");

  a_none_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (outcome_o == OUT_NONE)) |->
      ((first_x_o == '0) && (first_y_o == '0) && (second_x_o == '0) && (second_y_o == '0)))
    else $error("no intersection with nonzero coordinates");

  a_point_same : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (outcome_o == OUT_POINT)) |->
      ((first_x_o == second_x_o) && (first_y_o == second_y_o)))
    else $error("single point with differing endpoints");

endmodule

### rtl/seg_isect_front.sv
// front end: differences, cross products, range tests, parallel cases and
// the crossing numerators prepared for the divider chain; uses seg_isect_pkg
module seg_isect_front #(
  parameter int COORD_WIDTH = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            in_valid_i,
  input  logic signed [COORD_WIDTH-1:0]   a_start_x_i,
  input  logic signed [COORD_WIDTH-1:0]   a_start_y_i,
  input  logic signed [COORD_WIDTH-1:0]   a_end_x_i,
  input  logic signed [COORD_WIDTH-1:0]   a_end_y_i,
  input  logic signed [COORD_WIDTH-1:0]   b_start_x_i,
  input  logic signed [COORD_WIDTH-1:0]   b_start_y_i,
  input  logic signed [COORD_WIDTH-1:0]   b_end_x_i,
  input  logic signed [COORD_WIDTH-1:0]   b_end_y_i,
  output seg_isect_pkg::seg_ctl_t         ctl_o,
  output logic [2*COORD_WIDTH+1:0]        den_o,
  output logic [2*COORD_WIDTH+1:0]        rem_x_o,
  output logic [COORD_WIDTH+FRAC_BITS-1:0] bits_x_o,
  output logic [2*COORD_WIDTH+1:0]        rem_y_o,
  output logic [COORD_WIDTH+FRAC_BITS-1:0] bits_y_o,
  output logic [4*COORD_WIDTH-1:0]        pnt_o
);
  import seg_isect_pkg::*;

  localparam int C    = COORD_WIDTH;
  localparam int DW   = C + 1;
  localparam int XW   = 2 * C + 3;
  localparam int DENW = 2 * C + 2;
  localparam int Q    = C + FRAC_BITS;
  localparam int MW   = 3 * C + 4;
  localparam int NW   = 3 * C + 5;
  localparam int SW   = NW + FRAC_BITS;

  function automatic logic in_box(input logic signed [C-1:0] px, input logic signed [C-1:0] py,
                                  input logic signed [C-1:0] x1, input logic signed [C-1:0] y1,
                                  input logic signed [C-1:0] x2, input logic signed [C-1:0] y2);
    logic signed [C-1:0] lox, hix, loy, hiy;
    lox = (x1 < x2) ? x1 : x2;
    hix = (x1 > x2) ? x1 : x2;
    loy = (y1 < y2) ? y1 : y2;
    hiy = (y1 > y2) ? y1 : y2;
    return (px >= lox) && (px <= hix) && (py >= loy) && (py <= hiy);
  endfunction

  // stage 1: coordinates and differences
  logic v1_q;
  logic signed [C-1:0]  a1x_q, a1y_q, a2x_q, a2y_q, b1x_q, b1y_q, b2x_q, b2y_q;
  logic signed [DW-1:0] d1x_q, d1y_q, d2x_q, d2y_q, ex_q, ey_q;

  // stage 2: cross products and box tests
  logic v2_q;
  logic signed [C-1:0]  a1x2_q, a1y2_q, a2x2_q, a2y2_q, b1x2_q, b1y2_q, b2x2_q, b2y2_q;
  logic signed [DW-1:0] d1x2_q, d1y2_q;
  logic signed [XW-1:0] den_q, tn_q, un_q;
  logic apt_q, bpt_q, eqp_q, k1bb_q, k2bb_q, c1bb_q, c2bb_q;

  // stage 3: sign normalized, outcome decided
  seg_ctl_t ctl3_q;
  logic [4*C-1:0]       pnt3_q;
  logic signed [C-1:0]  a1x3_q, a1y3_q;
  logic signed [DW-1:0] d1x3_q, d1y3_q;
  logic [DENW-1:0]      dn3_q;
  logic signed [XW-1:0] tp3_q;

  // stage 4: products, stage 5: sums, stage 6: shifted magnitude
  seg_ctl_t ctl4_q, ctl5_q, ctl6_q;
  logic [4*C-1:0]       pnt4_q, pnt5_q, pnt6_q;
  logic [DENW-1:0]      dn4_q, dn5_q, dn6_q;
  logic signed [MW-1:0] mx1_q, mx2_q, my1_q, my2_q;
  logic signed [NW-1:0] nx_q, ny_q;
  logic [DENW-1:0]      remx_q, remy_q;
  logic [Q-1:0]         bitsx_q, bitsy_q;

  // stage 2 logic
  logic signed [2*DW-1:0] p_a, p_b, p_c, p_d, p_e, p_f;
  logic signed [XW-1:0]   den_d, tn_d, un_d;
  always_comb begin
    p_a   = d1x_q * d2y_q;
    p_b   = d1y_q * d2x_q;
    p_c   = ex_q * d2y_q;
    p_d   = ey_q * d2x_q;
    p_e   = ex_q * d1y_q;
    p_f   = ey_q * d1x_q;
    den_d = XW'(p_a) - XW'(p_b);
    tn_d  = XW'(p_c) - XW'(p_d);
    un_d  = XW'(p_e) - XW'(p_f);
  end

  // stage 3 logic
  logic                 neg3;
  logic signed [XW-1:0] dabs, tp_d, up_d;
  logic                 inr, hit, k1, k2, c1, c2;
  logic signed [C-1:0]  px, py, qx, qy;
  seg_ctl_t             ctl3_d;
  always_comb begin
    neg3 = den_q[XW-1];
    dabs = neg3 ? -den_q : den_q;
    tp_d = neg3 ? -tn_q : tn_q;
    up_d = neg3 ? -un_q : un_q;
    inr  = (den_q != '0) && !tp_d[XW-1] && (tp_d <= dabs) && !up_d[XW-1] && (up_d <= dabs);
    // with parallel lines the endpoint cross products reduce to tn and un
    k1   = (tn_q == '0) && k1bb_q;
    k2   = (tn_q == '0) && k2bb_q;
    c1   = (un_q == '0) && c1bb_q;
    c2   = (un_q == '0) && c2bb_q;
    hit  = 1'b0;
    px   = '0;
    py   = '0;
    qx   = '0;
    qy   = '0;
    if (den_q == '0) begin
      if (apt_q && bpt_q) begin
        hit = eqp_q;
        px = a1x2_q; py = a1y2_q; qx = a1x2_q; qy = a1y2_q;
      end else if (apt_q) begin
        hit = k1;
        px = a1x2_q; py = a1y2_q; qx = a1x2_q; qy = a1y2_q;
      end else if (bpt_q) begin
        hit = c1;
        px = b1x2_q; py = b1y2_q; qx = b1x2_q; qy = b1y2_q;
      end else if (un_q == '0) begin
        if (k1 && k2) begin
          hit = 1'b1;
          px = a1x2_q; py = a1y2_q; qx = a2x2_q; qy = a2y2_q;
        end else if (k1 || k2) begin
          hit = 1'b1;
          px = k1 ? a1x2_q : a2x2_q; py = k1 ? a1y2_q : a2y2_q;
          qx = c1 ? b1x2_q : b2x2_q; qy = c1 ? b1y2_q : b2y2_q;
        end else if (c1 && c2) begin
          hit = 1'b1;
          px = b1x2_q; py = b1y2_q; qx = b2x2_q; qy = b2y2_q;
        end else if (c1 || c2) begin
          hit = 1'b1;
          px = c1 ? b1x2_q : b2x2_q; py = c1 ? b1y2_q : b2y2_q;
          qx = k1 ? a1x2_q : a2x2_q; qy = k1 ? a1y2_q : a2y2_q;
        end
      end
      if (!hit) begin
        px = '0; py = '0; qx = '0; qy = '0;
      end
    end
    ctl3_d.valid  = v2_q;
    ctl3_d.is_div = inr;
    ctl3_d.neg_x  = 1'b0;
    ctl3_d.neg_y  = 1'b0;
    if (inr) begin
      ctl3_d.outcome = OUT_POINT;
    end else if (hit) begin
      ctl3_d.outcome = ((px == qx) && (py == qy)) ? OUT_POINT : OUT_OVERLAP;
    end else begin
      ctl3_d.outcome = OUT_NONE;
    end
  end

  // stage 4 logic
  logic signed [MW-1:0] mx1_d, mx2_d, my1_d, my2_d;
  always_comb begin
    mx1_d = MW'(a1x3_q * $signed({1'b0, dn3_q}));
    mx2_d = MW'(d1x3_q * tp3_q);
    my1_d = MW'(a1y3_q * $signed({1'b0, dn3_q}));
    my2_d = MW'(d1y3_q * tp3_q);
  end

  // stage 6 logic
  logic signed [SW-1:0] shx, shy;
  logic [SW-1:0]        magx, magy;
  seg_ctl_t             ctl6_d;
  always_comb begin
    shx  = SW'(nx_q);
    shx  = shx <<< FRAC_BITS;
    shy  = SW'(ny_q);
    shy  = shy <<< FRAC_BITS;
    magx = shx[SW-1] ? SW'(-shx) : SW'(shx);
    magy = shy[SW-1] ? SW'(-shy) : SW'(shy);
    ctl6_d       = ctl5_q;
    ctl6_d.neg_x = shx[SW-1];
    ctl6_d.neg_y = shy[SW-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      ctl3_q <= '0;
      ctl4_q <= '0;
      ctl5_q <= '0;
      ctl6_q <= '0;
    end else if (en_i) begin
      v1_q   <= in_valid_i;
      v2_q   <= v1_q;
      ctl3_q <= ctl3_d;
      ctl4_q <= ctl3_q;
      ctl5_q <= ctl4_q;
      ctl6_q <= ctl6_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1x_q <= a_start_x_i;
      a1y_q <= a_start_y_i;
      a2x_q <= a_end_x_i;
      a2y_q <= a_end_y_i;
      b1x_q <= b_start_x_i;
      b1y_q <= b_start_y_i;
      b2x_q <= b_end_x_i;
      b2y_q <= b_end_y_i;
      d1x_q <= DW'(a_end_x_i) - DW'(a_start_x_i);
      d1y_q <= DW'(a_end_y_i) - DW'(a_start_y_i);
      d2x_q <= DW'(b_end_x_i) - DW'(b_start_x_i);
      d2y_q <= DW'(b_end_y_i) - DW'(b_start_y_i);
      ex_q  <= DW'(b_start_x_i) - DW'(a_start_x_i);
      ey_q  <= DW'(b_start_y_i) - DW'(a_start_y_i);

      a1x2_q <= a1x_q;
      a1y2_q <= a1y_q;
      a2x2_q <= a2x_q;
      a2y2_q <= a2y_q;
      b1x2_q <= b1x_q;
      b1y2_q <= b1y_q;
      b2x2_q <= b2x_q;
      b2y2_q <= b2y_q;
      d1x2_q <= d1x_q;
      d1y2_q <= d1y_q;
      den_q  <= den_d;
      tn_q   <= tn_d;
      un_q   <= un_d;
      apt_q  <= (d1x_q == '0) && (d1y_q == '0);
      bpt_q  <= (d2x_q == '0) && (d2y_q == '0);
      eqp_q  <= (a1x_q == b1x_q) && (a1y_q == b1y_q);
      k1bb_q <= in_box(a1x_q, a1y_q, b1x_q, b1y_q, b2x_q, b2y_q);
      k2bb_q <= in_box(a2x_q, a2y_q, b1x_q, b1y_q, b2x_q, b2y_q);
      c1bb_q <= in_box(b1x_q, b1y_q, a1x_q, a1y_q, a2x_q, a2y_q);
      c2bb_q <= in_box(b2x_q, b2y_q, a1x_q, a1y_q, a2x_q, a2y_q);

      pnt3_q <= {px, py, qx, qy};
      a1x3_q <= a1x2_q;
      a1y3_q <= a1y2_q;
      d1x3_q <= d1x2_q;
      d1y3_q <= d1y2_q;
      dn3_q  <= dabs[DENW-1:0];
      tp3_q  <= tp_d;

      pnt4_q <= pnt3_q;
      dn4_q  <= dn3_q;
      mx1_q  <= mx1_d;
      mx2_q  <= mx2_d;
      my1_q  <= my1_d;
      my2_q  <= my2_d;

      pnt5_q <= pnt4_q;
      dn5_q  <= dn4_q;
      nx_q   <= NW'(mx1_q) + NW'(mx2_q);
      ny_q   <= NW'(my1_q) + NW'(my2_q);

      pnt6_q  <= pnt5_q;
      dn6_q   <= dn5_q;
      // the quotient fits in Q bits, so the high part starts below the divisor
      remx_q  <= magx[Q+DENW-1:Q];
      remy_q  <= magy[Q+DENW-1:Q];
      bitsx_q <= magx[Q-1:0];
      bitsy_q <= magy[Q-1:0];
    end
  end

  assign ctl_o    = ctl6_q;
  assign den_o    = dn6_q;
  assign rem_x_o  = remx_q;
  assign bits_x_o = bitsx_q;
  assign rem_y_o  = remy_q;
  assign bits_y_o = bitsy_q;
  assign pnt_o    = pnt6_q;

endmodule

### rtl/seg_isect_cell.sv
// one restoring division step for the x and y lanes, registered
// uses seg_isect_pkg for the control struct
module seg_isect_cell #(
  parameter int DENW = 34,
  parameter int QW   = 32,
  parameter int PW   = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  seg_isect_pkg::seg_ctl_t  ctl_i,
  input  logic [DENW-1:0]          den_i,
  input  logic [DENW-1:0]          rem_x_i,
  input  logic [QW-1:0]            bits_x_i,
  input  logic [DENW-1:0]          rem_y_i,
  input  logic [QW-1:0]            bits_y_i,
  input  logic [PW-1:0]            pnt_i,
  output seg_isect_pkg::seg_ctl_t  ctl_o,
  output logic [DENW-1:0]          den_o,
  output logic [DENW-1:0]          rem_x_o,
  output logic [QW-1:0]            bits_x_o,
  output logic [DENW-1:0]          rem_y_o,
  output logic [QW-1:0]            bits_y_o,
  output logic [PW-1:0]            pnt_o
);
  import seg_isect_pkg::*;

  seg_ctl_t          ctl_q;
  logic [DENW-1:0]   den_q, remx_q, remy_q;
  logic [QW-1:0]     bitsx_q, bitsy_q;
  logic [PW-1:0]     pnt_q;

  logic [DENW:0]     rsx, rsy;
  logic [DENW+1:0]   dfx, dfy;
  logic              gex, gey;
  logic [DENW-1:0]   remx_d, remy_d;
  logic [QW-1:0]     bitsx_d, bitsy_d;

  always_comb begin
    // bring down the next numerator bit, then try the subtract
    rsx     = {rem_x_i, bits_x_i[QW-1]};
    rsy     = {rem_y_i, bits_y_i[QW-1]};
    dfx     = {1'b0, rsx} - {2'b00, den_i};
    dfy     = {1'b0, rsy} - {2'b00, den_i};
    gex     = !dfx[DENW+1];
    gey     = !dfy[DENW+1];
    remx_d  = gex ? dfx[DENW-1:0] : rsx[DENW-1:0];
    remy_d  = gey ? dfy[DENW-1:0] : rsy[DENW-1:0];
    bitsx_d = bits_x_i << 1;
    bitsy_d = bits_y_i << 1;
    bitsx_d[0] = gex;
    bitsy_d[0] = gey;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q   <= den_i;
      remx_q  <= remx_d;
      remy_q  <= remy_d;
      bitsx_q <= bitsx_d;
      bitsy_q <= bitsy_d;
      pnt_q   <= pnt_i;
    end
  end

  assign ctl_o    = ctl_q;
  assign den_o    = den_q;
  assign rem_x_o  = remx_q;
  assign bits_x_o = bitsx_q;
  assign rem_y_o  = remy_q;
  assign bits_y_o = bitsy_q;
  assign pnt_o    = pnt_q;

endmodule
